>>> rtl/core/mmc_pkg.sv
// Package for the modular multinomial coefficient block: widths, the prime,
// the multiplier depth and the payload structs. No dependencies.
package mmc_pkg;
    localparam int TableSize = 262144;
    localparam int AddrW = $clog2(TableSize);
    localparam int IdxW = 18;
    localparam int CoefW = 30;
    localparam logic [CoefW-1:0] PrimeMod = 30'd1000000007;
    // Number of pipeline stages in mmc_mulmod.
    localparam int MulLat = 6;

    typedef struct packed {
        logic [IdxW-1:0] top_count;
        logic [IdxW-1:0] part_a;
        logic [IdxW-1:0] part_b;
        logic [IdxW-1:0] part_c;
    } query_t;

    typedef struct packed {
        logic [CoefW-1:0] coefficient;
        logic             out_of_range;
    } result_t;

    // An index is in range when it is below the table size.
    function automatic logic idx_ok(input logic [IdxW-1:0] idx);
        logic [IdxW:0] wide;
        wide = {1'b0, idx};
        idx_ok = (32'(wide) < TableSize);
    endfunction
endpackage

>>> rtl/core/mmc_if.sv
// Valid/ready channel interfaces for queries and results.
// Depends on mmc_pkg.
interface mmc_query_if;
    import mmc_pkg::*;
    logic   valid;
    logic   ready;
    query_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mmc_result_if;
    import mmc_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/mmc_mulmod.sv
// Pipelined multiply modulo the prime: 30x30 product over 16-bit partial
// products, then a Barrett reduction and correction. Depends on mmc_pkg.
module mmc_mulmod (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [mmc_pkg::CoefW-1:0] a,
    input  logic [mmc_pkg::CoefW-1:0] b,
    output logic                      out_valid,
    output logic [mmc_pkg::CoefW-1:0] y
);
    import mmc_pkg::*;

    // For x < 2^60, ((x >> 29) * floor(2^60 / p)) >> 31 falls short of x / p
    // by at most two, so two conditional subtractions complete the reduction.
    localparam logic [30:0] RecipM = 31'd1152921496;

    logic [MulLat-1:0] v_reg;
    logic [31:0]       pll_reg;
    logic [29:0]       plh_reg, phl_reg;
    logic [27:0]       phh_reg;
    logic [59:0]       prod_reg;
    logic [30:0]       q3_reg;
    logic [31:0]       x3_reg;
    logic [31:0]       qp_reg;
    logic [31:0]       x4_reg;
    logic [31:0]       r_reg;
    logic [CoefW-1:0]  y_reg;

    logic [61:0]       q2_full;
    logic [31:0]       qp_lo;
    logic [31:0]       p1;
    logic [31:0]       p2;
    logic [CoefW-1:0]  y_next;

    assign p1      = {2'b00, PrimeMod};
    assign p2      = {1'b0, PrimeMod, 1'b0};
    assign q2_full = {31'd0, prod_reg[59:29]} * {31'd0, RecipM};
    assign qp_lo   = 32'({30'd0, q3_reg} * {31'd0, PrimeMod});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[MulLat-2:0], in_valid};
        end
    end

    always_comb
    begin
        priority if (r_reg >= p2)
        begin
            y_next = CoefW'(r_reg - p2);
        end
        else if (r_reg >= p1)
        begin
            y_next = CoefW'(r_reg - p1);
        end
        else
        begin
            y_next = r_reg[CoefW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pll_reg  <= {16'd0, a[15:0]} * {16'd0, b[15:0]};
            plh_reg  <= {14'd0, a[15:0]} * {16'd0, b[29:16]};
            phl_reg  <= {16'd0, a[29:16]} * {14'd0, b[15:0]};
            phh_reg  <= {14'd0, a[29:16]} * {14'd0, b[29:16]};
            prod_reg <= {phh_reg, 32'd0} + {14'd0, plh_reg, 16'd0}
                        + {14'd0, phl_reg, 16'd0} + {28'd0, pll_reg};
            q3_reg   <= q2_full[61:31];
            x3_reg   <= prod_reg[31:0];
            qp_reg   <= qp_lo;
            x4_reg   <= x3_reg;
            r_reg    <= x4_reg - qp_reg;
            y_reg    <= y_next;
        end
    end

    assign out_valid = v_reg[MulLat-1];
    assign y = y_reg;
endmodule

>>> rtl/core/modular_multinomial_coefficient.sv
// Top level: factorial and inverse factorial tables in on-chip memory, their
// post-reset build, and the query pipeline. Depends on mmc_pkg, mmc_if, mmc_mulmod.
//
//   channel | dir | fields
//   query   | in  | top_count, part_a, part_b, part_c
//   result  | out | coefficient, out_of_range
//
// After reset the build keeps query.ready low: every table entry takes one round trip
// through the multiplier, forward for factorials and backward for inverse factorials,
// with a Fermat inversion of the last factorial (under 64 multiplies) in between.
// Afterwards one query transfers per cycle while results are taken; its result
// passes the table read register, two multiplier pipelines and the output register.
// A stalled result freezes the whole query pipeline and holds query.ready low.
module modular_multinomial_coefficient (
    input  logic         clk,
    input  logic         rst_n,
    mmc_query_if.sink    query,
    mmc_result_if.source result
);
    import mmc_pkg::*;

    localparam logic [2:0] StInit = 3'd0;
    localparam logic [2:0] StFwd  = 3'd1;
    localparam logic [2:0] StSq   = 3'd2;
    localparam logic [2:0] StMul  = 3'd3;
    localparam logic [2:0] StLast = 3'd4;
    localparam logic [2:0] StBwd  = 3'd5;
    localparam logic [2:0] StDone = 3'd6;
    localparam int BitW = $clog2(CoefW);
    localparam int OorW = 2 * MulLat;
    localparam logic [CoefW-1:0] InvExp = PrimeMod - CoefW'(2);
    localparam logic [AddrW-1:0] LastIdx = AddrW'(TableSize - 1);

    // Each row of fx_mem holds {inverse factorial, factorial}.
    logic [2*CoefW-1:0] fx_mem [TableSize];
    logic [CoefW-1:0]   iy_mem [TableSize];

    logic [2:0]       st_reg;
    logic [AddrW-1:0] i_reg;
    logic [CoefW-1:0] acc_reg;
    logic [CoefW-1:0] base_reg;
    logic [BitW-1:0]  bit_reg;
    logic             pend_reg;

    logic             mm_iv;
    logic [CoefW-1:0] mm_a, mm_b;
    logic             mm_ov;
    logic [CoefW-1:0] mm_y;
    logic             fact_we;
    logic             ifact_we;
    logic [AddrW-1:0] w_addr;
    logic [CoefW-1:0] w_data;

    logic             adv;
    logic             q_fire;
    logic             oor_in;
    logic             s1_v_reg, s1_oor_reg;
    logic [CoefW-1:0] rf_reg, ra_reg, rb_reg, rc_reg;
    logic [OorW-1:0]  oor_pipe_reg;
    logic             out_v_reg;
    result_t          out_reg;

    logic             m1_ov, m2_ov, m3_ov;
    logic [CoefW-1:0] m1_y, m2_y, m3_y;

    assign adv         = !out_v_reg || result.ready;
    assign query.ready = (st_reg == StDone) && adv;
    assign q_fire      = query.valid && query.ready;

    assign mm_iv = !pend_reg && (st_reg == StFwd || st_reg == StSq ||
                                 st_reg == StMul || st_reg == StBwd);
    assign mm_a  = acc_reg;
    assign mm_b  = (st_reg == StSq) ? acc_reg :
                   (st_reg == StMul) ? base_reg : CoefW'(i_reg);

    assign fact_we  = (st_reg == StInit) || (st_reg == StFwd && mm_ov);
    assign ifact_we = (st_reg == StLast) || (st_reg == StBwd && mm_ov);
    assign w_addr   = (st_reg == StInit) ? '0 :
                      (st_reg == StBwd) ? i_reg - AddrW'(1) : i_reg;
    assign w_data   = (st_reg == StInit) ? CoefW'(1) :
                      (st_reg == StLast) ? acc_reg : mm_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= StInit;
            i_reg    <= AddrW'(1);
            acc_reg  <= CoefW'(1);
            base_reg <= '0;
            bit_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            if (mm_iv)
            begin
                pend_reg <= 1'b1;
            end
            else if (mm_ov)
            begin
                pend_reg <= 1'b0;
            end
            unique case (st_reg)
                StInit:
                begin
                    st_reg <= StFwd;
                end
                StFwd:
                begin
                    if (mm_ov)
                    begin
                        if (i_reg == LastIdx)
                        begin
                            base_reg <= mm_y;
                            acc_reg  <= CoefW'(1);
                            bit_reg  <= BitW'(CoefW - 1);
                            st_reg   <= StSq;
                        end
                        else
                        begin
                            acc_reg <= mm_y;
                            i_reg   <= i_reg + AddrW'(1);
                        end
                    end
                end
                StSq:
                begin
                    if (mm_ov)
                    begin
                        acc_reg <= mm_y;
                        if (InvExp[bit_reg])
                        begin
                            st_reg <= StMul;
                        end
                        else if (bit_reg == '0)
                        begin
                            st_reg <= StLast;
                        end
                        else
                        begin
                            bit_reg <= bit_reg - BitW'(1);
                        end
                    end
                end
                StMul:
                begin
                    if (mm_ov)
                    begin
                        acc_reg <= mm_y;
                        if (bit_reg == '0)
                        begin
                            st_reg <= StLast;
                        end
                        else
                        begin
                            bit_reg <= bit_reg - BitW'(1);
                            st_reg  <= StSq;
                        end
                    end
                end
                StLast:
                begin
                    st_reg <= StBwd;
                end
                StBwd:
                begin
                    if (mm_ov)
                    begin
                        acc_reg <= mm_y;
                        if (i_reg == AddrW'(1))
                        begin
                            st_reg <= StDone;
                        end
                        else
                        begin
                            i_reg <= i_reg - AddrW'(1);
                        end
                    end
                end
                StDone:
                begin
                    st_reg <= StDone;
                end
                default:
                begin
                    st_reg <= StInit;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (fact_we)
        begin
            fx_mem[w_addr][CoefW-1:0] <= w_data;
        end
        if (ifact_we)
        begin
            fx_mem[w_addr][2*CoefW-1:CoefW] <= w_data;
            iy_mem[w_addr]                  <= w_data;
        end
    end

    mmc_mulmod u_bmul (
        .clk(clk), .rst_n(rst_n), .en(1'b1), .in_valid(mm_iv), .a(mm_a), .b(mm_b),
        .out_valid(mm_ov), .y(mm_y)
    );

    assign oor_in = !(idx_ok(query.data.top_count) && idx_ok(query.data.part_a)
                      && idx_ok(query.data.part_b) && idx_ok(query.data.part_c));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg  <= q_fire;
            out_v_reg <= m3_ov;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rf_reg       <= fx_mem[query.data.top_count[AddrW-1:0]][CoefW-1:0];
            ra_reg       <= fx_mem[query.data.part_a[AddrW-1:0]][2*CoefW-1:CoefW];
            rb_reg       <= iy_mem[query.data.part_b[AddrW-1:0]];
            rc_reg       <= iy_mem[query.data.part_c[AddrW-1:0]];
            s1_oor_reg   <= oor_in;
            oor_pipe_reg <= {oor_pipe_reg[OorW-2:0], s1_oor_reg};
            out_reg.coefficient  <= oor_pipe_reg[OorW-1] ? '0 : m3_y;
            out_reg.out_of_range <= oor_pipe_reg[OorW-1];
        end
    end

    mmc_mulmod u_q1 (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(s1_v_reg), .a(rf_reg), .b(ra_reg),
        .out_valid(m1_ov), .y(m1_y)
    );
    mmc_mulmod u_q2 (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(s1_v_reg), .a(rb_reg), .b(rc_reg),
        .out_valid(m2_ov), .y(m2_y)
    );
    mmc_mulmod u_q3 (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(m1_ov), .a(m1_y), .b(m2_y),
        .out_valid(m3_ov), .y(m3_y)
    );

    assign result.valid = out_v_reg;
    assign result.data  = out_reg;

    a_no_ready_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != StDone) |-> !query.ready) else $error("ready during build");
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.out_of_range) |-> (result.data.coefficient == '0))
        else $error("out of range result not zero");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> (result.valid && $stable(result.data)))
        else $error("result changed while stalled");
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        m1_ov == m2_ov) else $error("query multipliers out of step");
endmodule

>>> tb/sv/tb_modular_multinomial_coefficient.sv
// Testbench for modular_multinomial_coefficient: drives queries, predicts each
// multinomial value from tables built here, and checks every result transfer.
// Depends on mmc_pkg, mmc_if and the block's RTL.
module tb_modular_multinomial_coefficient;
    timeunit 1ns;
    timeprecision 1ps;
    import mmc_pkg::*;

    localparam longint Prime = 64'd1000000007;

    class coefficient_scoreboard;
        bit [CoefW-1:0] fact_tab[TableSize];
        bit [CoefW-1:0] inv_fact_tab[TableSize];
        result_t expected_q[$];
        int errors;
        int checked;

        function new();
            bit [CoefW-1:0] inv_tab[TableSize];
            longint q;
            longint r;
            errors = 0;
            checked = 0;
            fact_tab[0] = 1;
            inv_tab[0] = 1;
            inv_fact_tab[0] = 1;
            fact_tab[1] = 1;
            inv_tab[1] = 1;
            inv_fact_tab[1] = 1;
            for (int i = 2; i < TableSize; i++)
            begin
                q = Prime / i;
                r = Prime % i;
                fact_tab[i] = CoefW'((longint'(fact_tab[i-1]) * i) % Prime);
                inv_tab[i] = CoefW'(((Prime - q) * longint'(inv_tab[r])) % Prime);
                inv_fact_tab[i] =
                    CoefW'((longint'(inv_fact_tab[i-1]) * longint'(inv_tab[i])) % Prime);
            end
        endfunction

        function void note_query(query_t qr);
            result_t e;
            longint acc;
            if (32'(qr.top_count) >= TableSize || 32'(qr.part_a) >= TableSize ||
                32'(qr.part_b) >= TableSize || 32'(qr.part_c) >= TableSize)
            begin
                e.coefficient = '0;
                e.out_of_range = 1'b1;
            end
            else
            begin
                acc = fact_tab[qr.top_count];
                acc = (acc * longint'(inv_fact_tab[qr.part_b])) % Prime;
                acc = (acc * longint'(inv_fact_tab[qr.part_a])) % Prime;
                acc = (acc * longint'(inv_fact_tab[qr.part_c])) % Prime;
                e.coefficient = CoefW'(acc);
                e.out_of_range = 1'b0;
            end
            expected_q = {expected_q, e};
        endfunction

        function void check_result(result_t got);
            result_t e;
            checked++;
            if (expected_q.size() == 0)
            begin
                $error("result transfer with no query outstanding");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.coefficient !== e.coefficient)
            begin
                $error("coefficient: expected %0d, actual %0d", e.coefficient, got.coefficient);
                errors++;
            end
            if (got.out_of_range !== e.out_of_range)
            begin
                $error("out_of_range: expected %0d, actual %0d",
                       e.out_of_range, got.out_of_range);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    mmc_query_if query ();
    mmc_result_if result ();
    coefficient_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int sent;

    modular_multinomial_coefficient DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query.sink),
        .result (result.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        result.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result.valid === 1'b1 && result.ready === 1'b1)
                sb.check_result(result.data);
            result.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_query(input query_t qr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            query.valid <= 1'b0;
            @(posedge clk);
        end
        query.valid <= 1'b1;
        query.data <= qr;
        @(posedge clk);
        while (query.ready !== 1'b1)
            @(posedge clk);
        sb.note_query(qr);
        sent++;
    endtask

    function automatic query_t random_query();
        query_t qr;
        logic [95:0] raw;
        int top;
        int rest;
        case ($urandom_range(3))
            0:
            begin
                raw = {$urandom, $urandom, $urandom};
                qr = raw[$bits(query_t)-1:0];
            end
            1:
            begin
                top = $urandom_range(TableSize - 1);
                qr.top_count = IdxW'(top);
                qr.part_a = IdxW'($urandom_range(top));
                rest = top - int'(qr.part_a);
                qr.part_b = IdxW'($urandom_range(rest));
                qr.part_c = IdxW'(rest - int'(qr.part_b));
            end
            2:
            begin
                top = $urandom_range(40);
                qr.top_count = IdxW'(top);
                qr.part_a = IdxW'($urandom_range(top));
                qr.part_b = IdxW'($urandom_range(top - int'(qr.part_a)));
                qr.part_c = IdxW'($urandom_range(top));
            end
            default:
            begin
                qr.top_count = IdxW'($urandom_range(TableSize - 1, TableSize - 64));
                qr.part_a = IdxW'($urandom_range(3));
                qr.part_b = IdxW'($urandom_range(TableSize - 1, TableSize - 64));
                qr.part_c = IdxW'($urandom);
            end
        endcase
        return qr;
    endfunction

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            send_query(random_query());
            if (i == count / 2 && idle_pct == 62 && stall_pct == 0)
            begin
                query.valid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0)
                    @(posedge clk);
            end
        end
    endtask

    initial
    begin
        query_t d;
        int drain;
        sb = new();
        sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        query.valid = 1'b0;
        query.data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        d = '0;
        send_query(d);
        d = '{top_count: '1, part_a: '0, part_b: '0, part_c: '0};
        send_query(d);
        d = '{top_count: '1, part_a: '1, part_b: '0, part_c: '0};
        send_query(d);
        d = '{top_count: '0, part_a: '1, part_b: '1, part_c: '1};
        send_query(d);
        d = '{top_count: '1, part_a: '1, part_b: '1, part_c: '1};
        send_query(d);
        d = '{top_count: 18'd1, part_a: 18'd1, part_b: 18'd0, part_c: 18'd0};
        send_query(d);
        d = '{top_count: 18'd2, part_a: 18'd1, part_b: 18'd1, part_c: 18'd0};
        send_query(d);
        d = '{top_count: 18'd10, part_a: 18'd3, part_b: 18'd3, part_c: 18'd4};
        send_query(d);
        d = '{top_count: 18'd5, part_a: 18'd9, part_b: 18'd2, part_c: 18'd7};
        send_query(d);
        d = '{top_count: 18'h2AAAA, part_a: 18'h15555, part_b: 18'h2AAAA,
              part_c: 18'h15555};
        send_query(d);
        d = '{top_count: 18'h15555, part_a: 18'h2AAAA, part_b: 18'h15555,
              part_c: 18'h2AAAA};
        send_query(d);
        d = '{top_count: 18'd131072, part_a: 18'd65536, part_b: 18'd65536,
              part_c: 18'd0};
        send_query(d);

        run_phase(0, 0, 470);
        run_phase(62, 0, 470);
        run_phase(0, 62, 470);
        run_phase(18, 18, 470);

        query.valid <= 1'b0;
        drain = 0;
        while (sb.pending() != 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        repeat (60) @(posedge clk);
        $display("Sent %0d queries across four handshake phases; %0d results checked.",
                 sent, sb.checked);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
